// ===== sv/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and codes of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned PEND_W = 2;
    localparam int unsigned PART_W = 10;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_TRUNC   = 2'd2;

    // Continuation bytes still expected.
    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              stream_end;
    } t_item;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic [STAT_W-1:0] status;
        logic              last_unit;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/u2u_in_reg.sv =====
// ----------------------------------------------------------------------------
// u2u_in_reg
// Input register stage: captures one byte transfer and holds it until the
// decode stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire u2u_pkg::t_item i_item,
    output logic               o_valid,
    output u2u_pkg::t_item     o_item,
    input  wire logic          i_take
);
    import u2u_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/u2u_decode.sv =====
// ----------------------------------------------------------------------------
// u2u_decode
// Sequence state and per-byte decode logic: gathers payload bits of multi-byte
// sequences and forms at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire u2u_pkg::t_item i_item,
    input  wire logic           i_take,
    output logic                o_res_valid,
    output u2u_pkg::t_result    o_res
);
    import u2u_pkg::*;

    logic [PEND_W-1:0] r_pending;
    logic [PART_W-1:0] r_partial;
    logic [PEND_W-1:0] n_pending;
    logic [PART_W-1:0] n_partial;
    logic [5:0]        payload;
    logic [BYTE_W-1:0] b;
    logic              last;

    assign b       = i_item.byte_in;
    assign last    = i_item.stream_end;
    assign payload = b[5:0];

    always_comb begin
        n_pending       = r_pending;
        n_partial       = r_partial;
        o_res_valid     = 1'b0;
        o_res.code_unit = '0;
        o_res.status    = ST_OK;
        o_res.last_unit = last;
        if (r_pending == PEND_ONE) begin
            o_res_valid     = 1'b1;
            o_res.code_unit = {r_partial, payload};
            n_pending       = PEND_NONE;
            n_partial       = '0;
        end else if (r_pending[1]) begin
            // Two continuations expected; a pending count of three acts the same.
            if (last) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_TRUNC;
                n_pending    = PEND_NONE;
                n_partial    = '0;
            end else begin
                n_partial = {r_partial[3:0], payload};
                n_pending = PEND_ONE;
            end
        end else if (!b[7]) begin
            o_res_valid     = 1'b1;
            o_res.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, b};
        end else if (b[7:4] == 4'hE) begin
            if (last) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_TRUNC;
            end else begin
                n_partial = {6'd0, b[3:0]};
                n_pending = PEND_TWO;
            end
        end else if (b[7:5] == 3'b110) begin
            if (last) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_TRUNC;
            end else begin
                n_partial = {5'd0, b[4:0]};
                n_pending = PEND_ONE;
            end
        end else begin
            // Lone continuation byte or a lead of a four-byte or longer form.
            o_res_valid  = 1'b1;
            o_res.status = ST_INVALID;
        end
        if (!i_valid) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= PEND_NONE;
            r_partial <= '0;
        end else if (i_take) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.stream_end) |=> (r_pending == PEND_NONE && r_partial == '0))
        else $error("state not cleared after end of stream");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK) |-> (o_res.code_unit == '0))
        else $error("nonzero code unit with error status");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_item.stream_end) |-> (o_res_valid && o_res.last_unit))
        else $error("end of stream without final result");

    a_last_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_unit) |-> i_item.stream_end)
        else $error("final result without end of stream");

endmodule

`default_nettype wire

// ===== sv/u2u_out_reg.sv =====
// ----------------------------------------------------------------------------
// u2u_out_reg
// Result register: holds one decoded unit until the output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire u2u_pkg::t_result i_res,
    output logic                  o_ready,
    output logic                  o_valid,
    output u2u_pkg::t_result      o_res,
    input  wire logic             i_ready
);
    import u2u_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8_to_ucs2_decoder.sv =====
// Path: a byte that completes a unit passes the input register and then the
// result register. The input register takes the byte at its input transfer,
// and the result register loads the unit when that byte leaves the input register.
// Throughput: one byte per cycle while the result register is free or the
// output is ready; the decode logic is a single shallow stage.
// Reset: synchronous active-low i_rst_n clears both valid flags and the
// pending sequence state; payload registers are not reset.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Streams UTF-8 bytes in and UCS-2 code units out, with status per unit.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] byte_in
    input  wire logic        i_s_tlast,   // stream_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [15:0] code_unit
    output logic [1:0]       o_m_tuser,   // [1:0] status
    output logic             o_m_tlast    // last_unit
);
    import u2u_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    t_result dec_res;
    t_result out_res;
    logic    stage_valid;
    logic    dec_valid;
    logic    out_ready;
    logic    take;

    assign in_item.byte_in    = i_s_tdata;
    assign in_item.stream_end = i_s_tlast;

    // A byte leaves the input register when it makes no result or the
    // result register can take the one it makes.
    assign take = stage_valid && (!dec_valid || out_ready);

    u2u_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (take)
    );

    u2u_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .i_take      (take),
        .o_res_valid (dec_valid),
        .o_res       (dec_res)
    );

    u2u_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dec_valid),
        .i_res   (dec_res),
        .o_ready (out_ready),
        .o_valid (o_m_tvalid),
        .o_res   (out_res),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = out_res.code_unit;
    assign o_m_tuser = out_res.status;
    assign o_m_tlast = out_res.last_unit;

endmodule

`default_nettype wire
